/* src/hashed_allocation_counter_table_defines.svh */
// ----------------------------------------------------------------------------
// hashed_allocation_counter_table_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef HASHED_ALLOCATION_COUNTER_TABLE_DEFINES_SVH
`define HASHED_ALLOCATION_COUNTER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HACT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hact check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define HACT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hact check failed");

`endif

/* src/hact_pkg.sv */
// ----------------------------------------------------------------------------
// hact_pkg
// Shared types, constants and hash coefficients of the allocation counter
// table.
// ----------------------------------------------------------------------------
package hact_pkg;

	localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

	localparam logic [31:0] HASH_K0 = 32'h9e3779b1;
	localparam logic [31:0] HASH_K1 = 32'h85ebca6b;
	localparam logic [31:0] HASH_K2 = 32'hc2b2ae35;
	localparam logic [31:0] HASH_K3 = 32'h27d4eb2f;

	localparam logic [31:0] SPILL_SITE = 32'hffff_fffe;

	localparam logic ACT_COUNT = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// One table slot as held in memory.
	typedef struct packed {
		logic        used;
		logic [55:0] key;
		logic [63:0] events;
		logic [63:0] requested;
		logic [63:0] charged;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_READ_RD,
		ST_READ_OUT
	} hact_state_t;

	// Hash unit handshake toward the sequencer.
	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} hash_status_t;

endpackage

/* src/hact_ram.sv */
// ----------------------------------------------------------------------------
// hact_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module hact_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/hact_hash.sv */
// ----------------------------------------------------------------------------
// hact_hash
// Key hash on one shared 32x32 multiplier: four products xored together,
// then folded with its upper half.
// ----------------------------------------------------------------------------
module hact_hash
	import hact_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [31:0]  site,
	input  logic [7:0]   storage,
	input  logic [7:0]   family,
	input  logic [7:0]   object,
	output hash_status_t status
);

	logic [2:0]  step_q;
	logic        run_q;
	logic [31:0] prod_s1;
	logic [31:0] acc_q;
	logic [31:0] op_a;
	logic [31:0] op_k;
	logic [63:0] prod_full;

	// Select operand and coefficient for this step
	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin op_a = site;             op_k = HASH_K0; end
			2'd1: begin op_a = {24'd0, storage}; op_k = HASH_K1; end
			2'd2: begin op_a = {24'd0, family};  op_k = HASH_K2; end
			default: begin op_a = {24'd0, object}; op_k = HASH_K3; end
		endcase
		prod_full = op_a * op_k;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
			run_q  <= 1'b0;
		end else if (start) begin
			step_q <= 3'd0;
			run_q  <= 1'b1;
		end else if (run_q) begin
			if (step_q == 3'd5) begin
				run_q <= 1'b0;
			end
			step_q <= step_q + 3'd1;
		end
	end

	// Multiply, then fold the product into the accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= 32'd0;
		end else if (run_q) begin
			if (step_q < 3'd4) begin
				prod_s1 <= prod_full[31:0];
			end
			if (step_q >= 3'd1 && step_q <= 3'd4) begin
				acc_q <= acc_q ^ prod_s1;
			end
		end
	end

	assign status.done  = run_q && (step_q == 3'd5);
	assign status.value = acc_q ^ {16'd0, acc_q[31:16]};

endmodule

/* src/hashed_allocation_counter_table.sv */
// ----------------------------------------------------------------------------
// hashed_allocation_counter_table
// Per-key allocation event counter on a linearly probed hash table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory, clearing every slot, and
// holds busy high. A count action hashes the key on the shared multiplier,
// then takes a memory read state and a compare state per probed slot (the
// slot is written on a hit or a claim); a read action of a slot takes a read
// state and an output state, while reading the overflow entry, reading beyond
// the overflow entry or a disabled count is answered from idle. The result beat
// follows in the cycle after the last of these, is shown for one cycle with
// done and cannot be held off; the next start is taken in that same cycle.
module hashed_allocation_counter_table
	import hact_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic signed [31:0]               site_key,
	input  logic [7:0]                       storage_kind,
	input  logic [7:0]                       family_kind,
	input  logic [7:0]                       object_kind,
	input  logic [31:0]                      req_bytes,
	input  logic [31:0]                      chg_bytes,
	input  logic [$clog2(TABLE_DEPTH):0]     read_slot,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,
	output logic                             done,
	output logic [$clog2(TABLE_DEPTH):0]     slot_index,
	output logic                             slot_occupied,
	output logic                             new_entry,
	output logic                             went_to_overflow,
	output logic signed [31:0]               entry_site,
	output logic [7:0]                       entry_storage,
	output logic [7:0]                       entry_family,
	output logic [7:0]                       entry_object,
	output logic [63:0]                      event_total,
	output logic [63:0]                      requested_total,
	output logic [63:0]                      charged_total
);

	localparam int unsigned AW    = $clog2(TABLE_DEPTH);
	localparam int unsigned IW    = AW + 1;
	localparam int unsigned LIMIT = TABLE_DEPTH * 3 / 4;
	localparam int unsigned EW    = $bits(slot_entry_t);

	localparam logic [IW-1:0] DEPTH_IDX = IW'(TABLE_DEPTH);
	localparam logic [IW-1:0] LIMIT_CNT = IW'(LIMIT);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

	hact_state_t  state_q, state_d;
	hash_status_t hash_st;

	logic          enabled_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] probe_q;
	logic [IW-1:0] used_cnt_q;
	logic [55:0]   key_q;
	logic [31:0]   rq_q;
	logic [31:0]   ch_q;
	logic [IW-1:0] rs_q;

	logic          spill_used_q;
	logic [63:0]   spill_ev_q;
	logic [63:0]   spill_rq_q;
	logic [63:0]   spill_ch_q;

	logic          accept;
	logic          hash_start;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	slot_entry_t   ram_wentry;
	slot_entry_t   ram_rentry;
	logic [EW-1:0] ram_rdata;

	logic          key_hit;
	logic          claim;
	logic          to_spill;
	logic [63:0]   upd_ev;
	logic [63:0]   upd_rq;
	logic [63:0]   upd_ch;
	logic [63:0]   spill_ev_d;
	logic [63:0]   spill_rq_d;
	logic [63:0]   spill_ch_d;

	// Result beat next values
	logic          emit;
	logic [IW-1:0] o_idx;
	logic          o_occ;
	logic          o_new;
	logic          o_spill;
	logic [55:0]   o_key;
	logic [63:0]   o_ev;
	logic [63:0]   o_rq;
	logic [63:0]   o_ch;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign cfg_ready  = 1'b1;
	assign hash_start = (state_q == ST_IDLE) && accept && (action == ACT_COUNT) && enabled_q;

	hact_hash u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hash_start),
		.site    (key_q[31:0]),
		.storage (key_q[39:32]),
		.family  (key_q[47:40]),
		.object  (key_q[55:48]),
		.status  (hash_st)
	);

	hact_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ram_rentry = slot_entry_t'(ram_rdata);

	// Compare and accumulate on the probed slot
	always_comb begin
		key_hit  = ram_rentry.used && (ram_rentry.key == key_q);
		claim    = !ram_rentry.used && (used_cnt_q < LIMIT_CNT);
		to_spill = (!ram_rentry.used && !claim) ||
			(ram_rentry.used && !key_hit && probe_q == LAST_SLOT);
		upd_ev   = ram_rentry.events + 64'd1;
		upd_rq   = ram_rentry.requested + {32'd0, rq_q};
		upd_ch   = ram_rentry.charged + {32'd0, ch_q};
		spill_ev_d = spill_ev_q + 64'd1;
		spill_rq_d = spill_rq_q + {32'd0, rq_q};
		spill_ch_d = spill_ch_q + {32'd0, ch_q};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_SLOT) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_READ) begin
						if (read_slot < DEPTH_IDX) state_d = ST_READ_RD;
					end else if (enabled_q) begin
						state_d = ST_HASH;
					end
				end
			end
			ST_HASH: begin
				if (hash_st.done) state_d = ST_PROBE_RD;
			end
			ST_PROBE_RD: state_d = ST_PROBE_CHK;
			ST_PROBE_CHK: begin
				if (claim || key_hit || to_spill) state_d = ST_IDLE;
				else state_d = ST_PROBE_RD;
			end
			ST_READ_RD:  state_d = ST_READ_OUT;
			ST_READ_OUT: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory control and result beat
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = slot_q;
		ram_raddr  = slot_q;
		ram_wentry = '0;
		emit    = 1'b0;
		o_idx   = '0;
		o_occ   = 1'b0;
		o_new   = 1'b0;
		o_spill = 1'b0;
		o_key   = '0;
		o_ev    = '0;
		o_rq    = '0;
		o_ch    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_READ) begin
						if (read_slot == DEPTH_IDX) begin
							emit  = 1'b1;
							o_idx = read_slot;
							o_occ = spill_used_q;
							o_key = spill_used_q ? {24'd0, SPILL_SITE} : 56'd0;
							o_ev  = spill_ev_q;
							o_rq  = spill_rq_q;
							o_ch  = spill_ch_q;
						end else if (read_slot > DEPTH_IDX) begin
							emit  = 1'b1;
							o_idx = read_slot;
						end
					end else if (!enabled_q) begin
						emit = 1'b1;
					end
				end
			end
			ST_PROBE_CHK: begin
				if (to_spill) begin
					emit    = 1'b1;
					o_idx   = DEPTH_IDX;
					o_occ   = 1'b1;
					o_spill = 1'b1;
					o_key   = {24'd0, SPILL_SITE};
					o_ev    = spill_ev_d;
					o_rq    = spill_rq_d;
					o_ch    = spill_ch_d;
				end else if (claim || key_hit) begin
					emit  = 1'b1;
					o_idx = {1'b0, slot_q};
					o_occ = 1'b1;
					o_new = claim;
					o_key = key_q;
					o_ev  = claim ? 64'd1 : upd_ev;
					o_rq  = claim ? {32'd0, rq_q} : upd_rq;
					o_ch  = claim ? {32'd0, ch_q} : upd_ch;
					ram_we               = 1'b1;
					ram_wentry.used      = 1'b1;
					ram_wentry.key       = key_q;
					ram_wentry.events    = o_ev;
					ram_wentry.requested = o_rq;
					ram_wentry.charged   = o_ch;
				end
			end
			ST_READ_RD: begin
				ram_raddr = rs_q[AW-1:0];
			end
			ST_READ_OUT: begin
				emit  = 1'b1;
				o_idx = rs_q;
				o_occ = ram_rentry.used;
				o_key = ram_rentry.key;
				o_ev  = ram_rentry.events;
				o_rq  = ram_rentry.requested;
				o_ch  = ram_rentry.charged;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			enabled_q    <= 1'b1;
			used_cnt_q   <= '0;
			spill_used_q <= 1'b0;
			spill_ev_q   <= '0;
			spill_rq_q   <= '0;
			spill_ch_q   <= '0;
			done         <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= emit;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_valid && cfg_ready) enabled_q <= cfg_data;
			if (state_q == ST_PROBE_CHK) begin
				if (to_spill) begin
					spill_used_q <= 1'b1;
					spill_ev_q   <= spill_ev_d;
					spill_rq_q   <= spill_rq_d;
					spill_ch_q   <= spill_ch_d;
				end else if (claim) begin
					used_cnt_q <= used_cnt_q + IW'(1);
				end
			end
		end
	end

	// Capture the beat, track the probe position
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {object_kind, family_kind, storage_kind, site_key};
			rq_q  <= req_bytes;
			ch_q  <= chg_bytes;
			rs_q  <= read_slot;
		end
		if (state_q == ST_HASH && hash_st.done) begin
			slot_q  <= hash_st.value[AW-1:0];
			probe_q <= '0;
		end else if (state_q == ST_PROBE_CHK) begin
			slot_q  <= slot_q + AW'(1);
			probe_q <= probe_q + AW'(1);
		end
		if (emit) begin
			slot_index       <= o_idx;
			slot_occupied    <= o_occ;
			new_entry        <= o_new;
			went_to_overflow <= o_spill;
			entry_site       <= o_key[31:0];
			entry_storage    <= o_key[39:32];
			entry_family     <= o_key[47:40];
			entry_object     <= o_key[55:48];
			event_total      <= o_ev;
			requested_total  <= o_rq;
			charged_total    <= o_ch;
		end
	end

endmodule

/* src/hact_checker.sv */
// ----------------------------------------------------------------------------
// hact_checker
// Port-level checks of the allocation counter table, bound to the top level.
// ----------------------------------------------------------------------------
`include "hashed_allocation_counter_table_defines.svh"

module hact_checker
	import hact_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [$clog2(TABLE_DEPTH):0] slot_index,
	input logic                         slot_occupied,
	input logic                         new_entry,
	input logic                         went_to_overflow,
	input logic signed [31:0]           entry_site,
	input logic [63:0]                  event_total
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH) + 1;
	localparam logic [IW-1:0] DEPTH_IDX = IW'(TABLE_DEPTH);

	// A result beat ends the item: block is idle again
	`HACT_ASSERT_NOW(a_done_idle, done, !busy)
	// Overflow beats carry the overflow key and index
	`HACT_ASSERT_NOW(a_spill_key, done && went_to_overflow, slot_occupied && entry_site == SPILL_SITE && slot_index == DEPTH_IDX)
	// A freshly claimed slot holds exactly one event
	`HACT_ASSERT_NOW(a_new_one, done && new_entry, !went_to_overflow && slot_occupied && event_total == 64'd1)
	// An accepted beat either answers at once or keeps the block busy
	`HACT_ASSERT_NEXT(a_start_busy, start && !busy, done || busy)

endmodule

bind hashed_allocation_counter_table hact_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_hact_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.slot_index       (slot_index),
	.slot_occupied    (slot_occupied),
	.new_entry        (new_entry),
	.went_to_overflow (went_to_overflow),
	.entry_site       (entry_site),
	.event_total      (event_total)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the allocation counter table. Commands are queued by
// an initial block, issued on start/busy, and scored against an in-bench table
// model that is updated as each command is taken. It fills the table past
// the claim limit so that overflow counting is exercised.
// ----------------------------------------------------------------------------
module tb;
	import hact_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CLAIM_LIMIT = DEPTH * 3 / 4;
	localparam int CFG_SETTLE = 20;
	localparam int CYCLE_LIMIT = 20000000;

	typedef enum logic [1:0] {REQ_CMD, REQ_CFG, REQ_DRAIN} req_kind_t;

	typedef struct {
		req_kind_t   kind;
		logic        act;
		logic [31:0] site;
		logic [7:0]  st, fa, ob;
		logic [31:0] rq, ch;
		logic [10:0] rs;
		bit          pick_used;
		logic        cfg_val;
		int          gap;
	} alloc_req_t;

	typedef struct packed {
		logic [10:0] idx;
		logic        occ, fresh, spilled;
		logic [31:0] site;
		logic [7:0]  st, fa, ob;
		logic [63:0] ev, rq, ch;
	} slot_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic action = 1'b0;
	logic signed [31:0] site_key = '0;
	logic [7:0] storage_kind = '0, family_kind = '0, object_kind = '0;
	logic [31:0] req_bytes = '0, chg_bytes = '0;
	logic [10:0] read_slot = '0;
	logic cfg_valid = 1'b0, cfg_ready, cfg_data = 1'b0;
	logic done;
	logic [10:0] slot_index;
	logic slot_occupied, new_entry, went_to_overflow;
	logic signed [31:0] entry_site;
	logic [7:0] entry_storage, entry_family, entry_object;
	logic [63:0] event_total, requested_total, charged_total;

	hashed_allocation_counter_table u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.site_key(site_key), .storage_kind(storage_kind), .family_kind(family_kind),
		.object_kind(object_kind), .req_bytes(req_bytes),
		.chg_bytes(chg_bytes), .read_slot(read_slot), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
		.slot_index(slot_index), .slot_occupied(slot_occupied), .new_entry(new_entry),
		.went_to_overflow(went_to_overflow), .entry_site(entry_site),
		.entry_storage(entry_storage), .entry_family(entry_family),
		.entry_object(entry_object), .event_total(event_total),
		.requested_total(requested_total), .charged_total(charged_total)
	);

	// Table model
	logic        tbl_on = 1'b1;
	bit          tbl_used [DEPTH];
	logic [55:0] tbl_key [DEPTH];
	logic [63:0] tbl_ev [DEPTH], tbl_rq [DEPTH], tbl_ch [DEPTH];
	int          tbl_count = 0;
	int          claimed_slots[$];
	bit          spill_on = 1'b0;
	logic [63:0] spill_ev = '0, spill_rq = '0, spill_ch = '0;

	alloc_req_t   pending_reqs[$];
	slot_report_t expected_reports[$];
	int errors = 0;
	int cycles = 0;
	int gap_left = 0;
	int settle = 0;

	initial forever #5 clk = ~clk;

	function automatic logic [31:0] key_hash(logic [31:0] s, logic [7:0] a, logic [7:0] b,
			logic [7:0] c);
		logic [31:0] h;
		h = s * HASH_K0;
		h = h ^ ({24'd0, a} * HASH_K1);
		h = h ^ ({24'd0, b} * HASH_K2);
		h = h ^ ({24'd0, c} * HASH_K3);
		return h ^ (h >> 16);
	endfunction

	// Apply one command to the model and return the report it should produce.
	function automatic slot_report_t count_or_read(alloc_req_t r);
		slot_report_t o;
		logic [55:0] k;
		int slot;
		o = '0;
		if (r.act == ACT_READ) begin
			o.idx = r.rs;
			if (r.rs < DEPTH) begin
				o.occ = tbl_used[r.rs];
				{o.ob, o.fa, o.st, o.site} = tbl_key[r.rs];
				o.ev = tbl_ev[r.rs];
				o.rq = tbl_rq[r.rs];
				o.ch = tbl_ch[r.rs];
			end else if (r.rs == DEPTH) begin
				o.occ = spill_on;
				o.site = spill_on ? SPILL_SITE : '0;
				o.ev = spill_ev;
				o.rq = spill_rq;
				o.ch = spill_ch;
			end
			return o;
		end
		if (!tbl_on)
			return o;
		k = {r.ob, r.fa, r.st, r.site};
		slot = int'(key_hash(r.site, r.st, r.fa, r.ob) & (DEPTH - 1));
		for (int p = 0; p < DEPTH; p++) begin
			if (!tbl_used[slot]) begin
				if (tbl_count >= CLAIM_LIMIT)
					break;
				tbl_used[slot] = 1'b1;
				tbl_key[slot] = k;
				tbl_ev[slot] = '0;
				tbl_rq[slot] = '0;
				tbl_ch[slot] = '0;
				tbl_count++;
				claimed_slots.push_back(slot);
				o.fresh = 1'b1;
			end
			if (tbl_key[slot] == k) begin
				tbl_ev[slot] += 64'd1;
				tbl_rq[slot] += {32'd0, r.rq};
				tbl_ch[slot] += {32'd0, r.ch};
				o.idx = 11'(slot);
				o.occ = 1'b1;
				{o.ob, o.fa, o.st, o.site} = k;
				o.ev = tbl_ev[slot];
				o.rq = tbl_rq[slot];
				o.ch = tbl_ch[slot];
				return o;
			end
			slot = (slot + 1) & (DEPTH - 1);
		end
		spill_on = 1'b1;
		spill_ev += 64'd1;
		spill_rq += {32'd0, r.rq};
		spill_ch += {32'd0, r.ch};
		o.idx = 11'(DEPTH);
		o.occ = 1'b1;
		o.spilled = 1'b1;
		o.site = SPILL_SITE;
		o.ev = spill_ev;
		o.rq = spill_rq;
		o.ch = spill_ch;
		return o;
	endfunction

	// Command driver: take beats, feed the model, launch the next command.
	always @(posedge clk or negedge arst_n) begin
		alloc_req_t r;
		logic nstart;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nstart = start;
			if (cfg_valid && cfg_ready) begin
				tbl_on = cfg_data;
				cfg_valid <= 1'b0;
			end
			if (start && !busy) begin
				r.kind = REQ_CMD;
				r.act = action;
				r.site = site_key;
				r.st = storage_kind;
				r.fa = family_kind;
				r.ob = object_kind;
				r.rq = req_bytes;
				r.ch = chg_bytes;
				r.rs = read_slot;
				expected_reports.push_back(count_or_read(r));
				nstart = 1'b0;
			end
			if (expected_reports.size() == 0 && !busy && !start && !cfg_valid)
				settle++;
			else
				settle = 0;
			if (!nstart && !cfg_valid && pending_reqs.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					r = pending_reqs[0];
					case (r.kind)
						REQ_CMD: begin
							void'(pending_reqs.pop_front());
							if (r.pick_used)
								r.rs = (claimed_slots.size() > 0) ?
									11'(claimed_slots[$urandom_range(0,
										claimed_slots.size() - 1)]) :
									11'(DEPTH);
							action <= r.act;
							site_key <= r.site;
							storage_kind <= r.st;
							family_kind <= r.fa;
							object_kind <= r.ob;
							req_bytes <= r.rq;
							chg_bytes <= r.ch;
							read_slot <= r.rs;
							nstart = 1'b1;
							gap_left = r.gap;
						end
						REQ_CFG: begin
							if (settle >= CFG_SETTLE) begin
								void'(pending_reqs.pop_front());
								cfg_data <= r.cfg_val;
								cfg_valid <= 1'b1;
							end
						end
						default: begin
							if (expected_reports.size() == 0 && !start)
								void'(pending_reqs.pop_front());
						end
					endcase
				end
			end
			start <= nstart;
		end
	end

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// Report monitor: score each done beat against the oldest prediction.
	always @(posedge clk) begin
		slot_report_t e;
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t unexpected report expected none actual slot %0d", $time,
					slot_index);
			end else begin
				e = expected_reports.pop_front();
				check_field("slot_index", e.idx, slot_index);
				check_field("slot_occupied", e.occ, slot_occupied);
				check_field("new_entry", e.fresh, new_entry);
				check_field("went_to_overflow", e.spilled, went_to_overflow);
				check_field("entry_site", e.site, $unsigned(entry_site));
				check_field("entry_storage", e.st, entry_storage);
				check_field("entry_family", e.fa, entry_family);
				check_field("entry_object", e.ob, entry_object);
				check_field("event_total", e.ev, event_total);
				check_field("requested_total", e.rq, requested_total);
				check_field("charged_total", e.ch, charged_total);
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic int pick_gap(bit busy_phase);
		int u;
		if (!busy_phase)
			return 0;
		u = $urandom_range(0, 99);
		if (u < 50)
			return 0;
		if (u < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_count(logic [31:0] s, logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [31:0] q, logic [31:0] h, int g);
		alloc_req_t r;
		r = '{REQ_CMD, ACT_COUNT, s, a, b, c, q, h, 11'($urandom), 1'b0, 1'b0, g};
		pending_reqs.push_back(r);
	endtask

	task automatic add_read(logic [10:0] rs, bit pick, int g);
		alloc_req_t r;
		r = '{REQ_CMD, ACT_READ, $urandom, 8'($urandom), 8'($urandom), 8'($urandom),
			$urandom, $urandom, rs, pick, 1'b0, g};
		pending_reqs.push_back(r);
	endtask

	task automatic add_ctl(req_kind_t k, logic v);
		alloc_req_t r;
		r = '{k, ACT_COUNT, 32'd0, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0, 11'd0, 1'b0, v, 0};
		pending_reqs.push_back(r);
	endtask

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 3))
			0: return 32'hffff_ffff;
			1: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Stimulus and end of run
	initial begin
		logic [55:0] keys[$];
		logic [55:0] k;
		bit busy_phase;
		// directed: empty overflow, out-of-range reads, key and size extremes
		add_read(11'd1024, 1'b0, 0);
		add_read(11'd1025, 1'b0, 1);
		add_read(11'd2047, 1'b0, 0);
		add_count(32'h0000_0000, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 0);
		add_count(32'h7fff_ffff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 0);
		add_count(32'h8000_0000, 8'h00, 8'hff, 8'h00, 32'hffff_ffff, 32'h0, 2);
		add_count(32'hffff_ffff, 8'hff, 8'h00, 8'hff, 32'h0, 32'hffff_ffff, 0);
		add_count(32'hffff_fffe, 8'h00, 8'h00, 8'h00, 32'd7, 32'd8, 0);
		for (int i = 0; i < 4; i++)
			add_count(32'h7fff_ffff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, i);
		for (int i = 0; i < 3; i++)
			add_read(11'd0, 1'b1, 0);
		// disabled table: counts do nothing
		add_ctl(REQ_CFG, 1'b0);
		add_count(32'h1234_5678, 8'h12, 8'h34, 8'h56, 32'd100, 32'd200, 0);
		add_count(32'h7fff_ffff, 8'hff, 8'hff, 8'hff, 32'd1, 32'd1, 0);
		add_read(11'd1024, 1'b0, 0);
		add_read(11'd0, 1'b1, 0);
		add_ctl(REQ_CFG, 1'b1);
		add_count(32'h7fff_ffff, 8'hff, 8'hff, 8'hff, 32'd1, 32'd1, 0);
		add_read(11'd0, 1'b1, 0);

		// random: mostly new keys so the table crosses its claim limit
		busy_phase = 1'b1;
		for (int i = 0; i < 1550; i++) begin
			if (i % 100 == 0)
				busy_phase = ($urandom_range(0, 3) != 0);
			if (i == 700)
				add_ctl(REQ_CFG, 1'b0);
			if (i == 712)
				add_ctl(REQ_CFG, 1'b1);
			if (i == 400)
				add_ctl(REQ_DRAIN, 1'b0);
			if ($urandom_range(0, 99) < 80) begin
				if (keys.size() == 0 || $urandom_range(0, 99) < 70) begin
					k = {8'($urandom), 8'($urandom), 8'($urandom), 32'($urandom)};
					// near-duplicate keys differing only in the type bytes
					if ($urandom_range(0, 3) == 0 && keys.size() > 0) begin
						k = keys[$urandom_range(0, keys.size() - 1)];
						k[55:32] = 24'($urandom);
					end
					keys.push_back(k);
				end else begin
					k = keys[$urandom_range(0, keys.size() - 1)];
				end
				add_count(k[31:0], k[39:32], k[47:40], k[55:48], pick_size(), pick_size(),
					pick_gap(busy_phase));
			end else begin
				case ($urandom_range(0, 4))
					0: add_read(11'd1024, 1'b0, pick_gap(busy_phase));
					1: add_read(11'($urandom_range(1025, 2047)), 1'b0, pick_gap(busy_phase));
					default: add_read(11'd0, 1'b1, pick_gap(busy_phase));
				endcase
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && expected_reports.size() == 0 && !start);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_reports.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/hact_pkg.sv
src/hact_ram.sv
src/hact_hash.sv
src/hashed_allocation_counter_table.sv
src/hact_checker.sv
sim/tb.sv
